[rtl/core/cdo_pkg.sv]
// Shared types, constants and calendar helper functions for the date offset adder.
package cdo_pkg;

	// Default values for the top-level parameters.
	localparam int YEAR_LIMIT_DEF     = 9999;
	localparam int MAX_DAY_OFFSET_DEF = 1023;

	// Internal widths: the year is kept signed, wide enough for any sum or difference.
	localparam int YR_W      = 19;
	localparam int DAY_W     = 12;
	localparam int M400_W    = 9;
	localparam int REM_W     = 17;
	localparam int REM_STEPS = 2;
	localparam int CNT_W     = 2;

	// Remainder by 400: divide by 16 with a shift, then by 25 with a reciprocal multiply.
	// The reciprocal 10486 / 2^18 gives the exact quotient for every shifted value below 43690.
	localparam int          DIV16_SH    = 4;
	localparam int          RECIP_SHIFT = 18;
	localparam int          PROD_W      = 27;
	localparam logic [13:0] RECIP_25    = 14'd10486;

	// A multiple of 400 added to the year so that the remainder unit always sees a positive value.
	localparam logic [YR_W-1:0]   YEAR_BIAS = YR_W'(400 * 64);
	localparam logic [M400_W-1:0] QUAD_CENT = M400_W'(400);
	localparam logic [M400_W-1:0] QUAD_TOP  = M400_W'(399);

	// Operation select and status codes.
	localparam logic CMD_ADD     = 1'b0;
	localparam logic CMD_SUB     = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_SAT  = 1'b1;

	// Month numbers that the logic refers to.
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REM,
		ST_FIX,
		ST_LOOP,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rem_step;
		logic fix;
		logic loop_step;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic loop_done;
	} dp_stat_t;

	// Leap year test on the year taken modulo 400.
	function automatic logic leap_of(input logic [M400_W-1:0] m400);
		leap_of = (m400[1:0] == 2'd0) && (m400 != M400_W'(100)) &&
			(m400 != M400_W'(200)) && (m400 != M400_W'(300));
	endfunction

	// Length of a month, given whether its year is a leap year.
	function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
		logic [4:0] len;
		len = 5'd31;
		if (mo == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if ((mo == MONTH_APR) || (mo == MONTH_JUN) || (mo == MONTH_SEP) ||
				(mo == MONTH_NOV)) begin
			len = 5'd30;
		end
		month_len = len;
	endfunction

endpackage

[rtl/core/cdo_rem400.sv]
// Remainder of an unsigned value by 400, by reciprocal multiplication over two steps.
module cdo_rem400 import cdo_pkg::*; (
	input  logic                clk,
	input  logic                load,
	input  logic                step,
	input  logic [REM_W-1:0]    value,
	output logic [M400_W-1:0]   rem
);

	logic [REM_W-1:0]  val_q;
	logic [M400_W-1:0] quo_q;
	logic [M400_W-1:0] rem_q;
	logic [PROD_W-1:0] prod;
	logic [REM_W-1:0]  back;

	// Quotient by 400: the value divided by 16 with a shift, times the reciprocal of 25.
	assign prod = PROD_W'(val_q[REM_W-1:DIV16_SH]) * PROD_W'(RECIP_25);

	// The quotient times 400, to be taken back off the value.
	assign back = REM_W'(quo_q) * REM_W'(QUAD_CENT);

	// The first step forms the quotient and the second the remainder; the value holds meanwhile.
	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= value;
		end else if (step) begin
			quo_q <= prod[PROD_W-1:RECIP_SHIFT];
			rem_q <= M400_W'(val_q - back);
		end
	end

	assign rem = rem_q;

endmodule

[rtl/core/cdo_dp.sv]
// Datapath: field arithmetic, year remainders, month walk and result register.
module cdo_dp import cdo_pkg::*; #(
	parameter int YEAR_LIMIT     = YEAR_LIMIT_DEF,
	parameter int MAX_DAY_OFFSET = MAX_DAY_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic        op,
	input  logic [13:0] base_year,
	input  logic [3:0]  base_month,
	input  logic [4:0]  base_day,
	input  logic [4:0]  base_hour,
	input  logic [5:0]  base_minute,
	input  logic [13:0] offset_years,
	input  logic [3:0]  offset_months,
	input  logic [9:0]  offset_days,
	input  logic [4:0]  offset_hours,
	input  logic [5:0]  offset_minutes,
	output logic [13:0] result_year,
	output logic [3:0]  result_month,
	output logic [4:0]  result_day,
	output logic [4:0]  result_hour,
	output logic [5:0]  result_minute,
	output logic        status
);

	localparam logic [YR_W-1:0] LIMIT_Y = YR_W'(YEAR_LIMIT);
	localparam logic [16:0]     MAX_D   = 17'(MAX_DAY_OFFSET);

	// Saturated input fields.
	logic [YR_W-1:0] by_c;
	logic [3:0]      bmo_c, omo_c;
	logic [4:0]      bd_c, bh_c, oh_c;
	logic [5:0]      bmi_c, omi_c;
	logic [9:0]      od_c;

	// Minute, hour and month results with their carries.
	logic [6:0]      mi_sum;
	logic            mi_cy;
	logic [5:0]      mi_add, mi_sub, mi_n;
	logic [5:0]      h_sum, h_take;
	logic            h_cy, h_bw;
	logic [4:0]      h_n;
	logic            mi_bw, day_cy;
	logic [4:0]      mo_sum;
	logic            mo_cy, mo_bw;
	logic [3:0]      mo_n;
	logic [YR_W-1:0] y_n, y_bias;

	// Registers loaded with the item.
	logic            sub_q, dc_q, status_q;
	logic [3:0]      bmo_q, mo_q, month_q;
	logic [4:0]      bd_q, h_q, day_q, hour_q;
	logic [5:0]      mi_q, minute_q;
	logic [9:0]      od_q;
	logic [YR_W-1:0] y_q;
	logic [13:0]     year_q;
	logic [DAY_W-1:0]  d_q;
	logic [M400_W-1:0] m400_q, rem_y, rem_b;

	// Fix-up and loop signals.
	logic [4:0]        lim_b, bd_fix, len_c, len_dn;
	logic [DAY_W-1:0]  d_fix;
	logic [3:0]        mo_up, mo_dn;
	logic [M400_W-1:0] m400_up, m400_dn, m400_sub;

	// Saturate each field into its range; the base day is only raised from 0 here.
	always_comb begin
		by_c  = (YR_W'(base_year) > LIMIT_Y) ? LIMIT_Y : YR_W'(base_year);
		bmo_c = (base_month == 4'd0) ? MONTH_JAN :
			((base_month > MONTH_DEC) ? MONTH_DEC : base_month);
		bd_c  = (base_day == 5'd0) ? 5'd1 : base_day;
		bh_c  = (base_hour > 5'd23) ? 5'd23 : base_hour;
		bmi_c = (base_minute > 6'd59) ? 6'd59 : base_minute;
		omo_c = (offset_months > 4'd11) ? 4'd11 : offset_months;
		od_c  = (17'(offset_days) > MAX_D) ? MAX_D[9:0] : offset_days;
		oh_c  = (offset_hours > 5'd23) ? 5'd23 : offset_hours;
		omi_c = (offset_minutes > 6'd59) ? 6'd59 : offset_minutes;
	end

	// Minutes and hours, a single carry or borrow each.
	always_comb begin
		mi_sum = 7'(bmi_c) + 7'(omi_c);
		mi_cy  = (mi_sum >= 7'd60);
		mi_add = mi_cy ? 6'(mi_sum - 7'd60) : mi_sum[5:0];
		mi_bw  = (bmi_c < omi_c);
		mi_sub = mi_bw ? 6'(bmi_c + 6'd60 - omi_c) : 6'(bmi_c - omi_c);
		h_sum  = 6'(bh_c) + 6'(oh_c) + 6'(mi_cy);
		h_cy   = (h_sum >= 6'd24);
		h_take = 6'(oh_c) + 6'(mi_bw);
		h_bw   = (6'(bh_c) < h_take);
		if (op == CMD_SUB) begin
			mi_n   = mi_sub;
			h_n    = h_bw ? 5'(6'(bh_c) + 6'd24 - h_take) : 5'(6'(bh_c) - h_take);
			day_cy = h_bw;
		end else begin
			mi_n   = mi_add;
			h_n    = h_cy ? 5'(h_sum - 6'd24) : h_sum[4:0];
			day_cy = h_cy;
		end
	end

	// Months and years, a single carry or borrow.
	always_comb begin
		mo_sum = 5'(bmo_c) + 5'(omo_c);
		mo_cy  = (mo_sum > 5'(MONTH_DEC));
		mo_bw  = (bmo_c <= omo_c);
		if (op == CMD_SUB) begin
			mo_n = mo_bw ? 4'(bmo_c + MONTH_DEC - omo_c) : 4'(bmo_c - omo_c);
			y_n  = by_c - YR_W'(offset_years) - YR_W'(mo_bw);
		end else begin
			mo_n = mo_cy ? 4'(mo_sum - 5'(MONTH_DEC)) : mo_sum[3:0];
			y_n  = by_c + YR_W'(offset_years) + YR_W'(mo_cy);
		end
		y_bias = y_n + YEAR_BIAS;
	end

	// Year modulo 400 for the working year and for the base year.
	cdo_rem400 u_rem_y (
		.clk   (clk),
		.load  (cmd.load),
		.step  (cmd.rem_step),
		.value (y_bias[REM_W-1:0]),
		.rem   (rem_y)
	);

	cdo_rem400 u_rem_b (
		.clk   (clk),
		.load  (cmd.load),
		.step  (cmd.rem_step),
		.value (by_c[REM_W-1:0]),
		.rem   (rem_b)
	);

	// Clamp the base day to its month and form the starting day count.
	always_comb begin
		lim_b  = month_len(bmo_q, leap_of(rem_b));
		bd_fix = (bd_q > lim_b) ? lim_b : bd_q;
		if (sub_q == CMD_SUB) begin
			d_fix = DAY_W'(bd_fix) - DAY_W'(od_q) - DAY_W'(dc_q);
		end else begin
			d_fix = DAY_W'(bd_fix) + DAY_W'(od_q) + DAY_W'(dc_q);
		end
	end

	// One month crossed per step, in either direction.
	always_comb begin
		len_c    = month_len(mo_q, leap_of(m400_q));
		mo_up    = (mo_q == MONTH_DEC) ? MONTH_JAN : 4'(mo_q + 4'd1);
		mo_dn    = (mo_q == MONTH_JAN) ? MONTH_DEC : 4'(mo_q - 4'd1);
		m400_up  = (m400_q == QUAD_TOP) ? '0 : M400_W'(m400_q + M400_W'(1));
		m400_dn  = (m400_q == '0) ? QUAD_TOP : M400_W'(m400_q - M400_W'(1));
		m400_sub = (mo_q == MONTH_JAN) ? m400_dn : m400_q;
		len_dn   = month_len(mo_dn, leap_of(m400_sub));
		if (sub_q == CMD_SUB) begin
			stat.loop_done = ($signed(d_q) >= $signed(DAY_W'(1)));
		end else begin
			stat.loop_done = ($signed(d_q) <= $signed(DAY_W'(len_c)));
		end
	end

	always_ff @(posedge clk) begin
		// Capture the item with its field arithmetic done.
		if (cmd.load) begin
			sub_q <= op;
			bmo_q <= bmo_c;
			bd_q  <= bd_c;
			od_q  <= od_c;
			dc_q  <= day_cy;
			mi_q  <= mi_n;
			h_q   <= h_n;
			mo_q  <= mo_n;
			y_q   <= y_n;
		end
		// Starting day count and the year remainder for the walk.
		if (cmd.fix) begin
			d_q    <= d_fix;
			m400_q <= rem_y;
		end
		// Walk across one month boundary.
		if (cmd.loop_step) begin
			if (sub_q == CMD_SUB) begin
				mo_q <= mo_dn;
				d_q  <= d_q + DAY_W'(len_dn);
				if (mo_q == MONTH_JAN) begin
					y_q    <= y_q - YR_W'(1);
					m400_q <= m400_dn;
				end
			end else begin
				mo_q <= mo_up;
				d_q  <= d_q - DAY_W'(len_c);
				if (mo_q == MONTH_DEC) begin
					y_q    <= y_q + YR_W'(1);
					m400_q <= m400_up;
				end
			end
		end
		// Result register: clamp below at year 0, saturate above the limit.
		if (cmd.finish) begin
			if ($signed(y_q) > $signed(LIMIT_Y)) begin
				year_q   <= LIMIT_Y[13:0];
				month_q  <= MONTH_DEC;
				day_q    <= 5'd31;
				hour_q   <= 5'd23;
				minute_q <= 6'd59;
				status_q <= STATUS_SAT;
			end else begin
				year_q   <= ($signed(y_q) < 0) ? 14'd0 : y_q[13:0];
				month_q  <= mo_q;
				day_q    <= d_q[4:0];
				hour_q   <= h_q;
				minute_q <= mi_q;
				status_q <= STATUS_OK;
			end
		end
	end

	assign result_year   = year_q;
	assign result_month  = month_q;
	assign result_day    = day_q;
	assign result_hour   = hour_q;
	assign result_minute = minute_q;
	assign status        = status_q;

	// A finished walk leaves a real month and a day count that fits the result field.
	a_finish_month: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> ((mo_q >= MONTH_JAN) && (mo_q <= MONTH_DEC)))
		else $error("month out of range at finish");

	a_finish_day: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (($signed(d_q) >= $signed(DAY_W'(1))) &&
			($signed(d_q) <= $signed(DAY_W'(31)))))
		else $error("day out of range at finish");

endmodule

[rtl/core/cdo_ctrl.sv]
// Controller: sequences load, remainder, fix-up, month walk and result hand-off.
module cdo_ctrl import cdo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [CNT_W-1:0] REM_LAST = CNT_W'(REM_STEPS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] rem_cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	// The result register can take a new beat once the old one is gone or leaving.
	assign slot_free = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_REM;
			end
			ST_REM: begin
				if (rem_cnt_q == REM_LAST) state_d = ST_FIX;
			end
			ST_FIX: begin
				state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (stat.loop_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_REM: begin
				cmd.rem_step = 1'b1;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
			end
			ST_LOOP: begin
				cmd.loop_step = !stat.loop_done;
			end
			ST_DONE: begin
				cmd.finish = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Remainder step counter.
			if (cmd.load) begin
				rem_cnt_q <= '0;
			end else if (cmd.rem_step) begin
				rem_cnt_q <= CNT_W'(rem_cnt_q + CNT_W'(1));
			end
			// Result beat valid.
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	// An accepted beat always starts the remainder phase.
	a_load_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_REM))
		else $error("load did not start the remainder phase");

	// The result register is never overwritten while a beat still waits there.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result overwritten before it was taken");

	// The remainder counter stays within the step count.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REM) |-> (rem_cnt_q <= REM_LAST))
		else $error("remainder counter overran");

	// A result appears only in the cycle after the controller was in the done state.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result valid without a finished item");

endmodule

[rtl/core/calendar_date_offset_adder.sv]
// Top level of the calendar date offset adder: stream ports, controller and datapath.
// Takes one beat holding a base date and time plus an offset, adds or subtracts it, and
// returns the normalised date with a saturation flag. Items are handled one at a time.
// An item passes through these steps from acceptance to the next acceptance: the
// accepting cycle, the remainder of the year by 400 that drives the leap-year test (a
// reciprocal multiplication, then the subtraction), the day fix-up, the month walk at one
// month per cycle across each month boundary the day count crosses (up to about 35 months
// for a 1023-day offset) and the write of the result register. That last step waits while
// an earlier result is still held there and the receiver is not ready.
// The result sits in an output register, so a new beat is taken while it waits.
module calendar_date_offset_adder import cdo_pkg::*; #(
	parameter int YEAR_LIMIT     = YEAR_LIMIT_DEF,
	parameter int MAX_DAY_OFFSET = MAX_DAY_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// base_year, base_month, base_day, base_hour, base_minute, offset_years,
	// offset_months, offset_days, offset_hours, offset_minutes, zero padding
	input  logic [79:0] s_tdata,
	// cmd
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_year, result_month, result_day, result_hour, result_minute, zero padding
	output logic [39:0] m_tdata,
	// status
	output logic [0:0]  m_tuser
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [13:0] result_year;
	logic [3:0]  result_month;
	logic [4:0]  result_day;
	logic [4:0]  result_hour;
	logic [5:0]  result_minute;
	logic        status;

	cdo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdo_dp #(
		.YEAR_LIMIT     (YEAR_LIMIT),
		.MAX_DAY_OFFSET (MAX_DAY_OFFSET)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (s_tuser[0]),
		.base_year      (s_tdata[13:0]),
		.base_month     (s_tdata[17:14]),
		.base_day       (s_tdata[22:18]),
		.base_hour      (s_tdata[27:23]),
		.base_minute    (s_tdata[33:28]),
		.offset_years   (s_tdata[47:34]),
		.offset_months  (s_tdata[51:48]),
		.offset_days    (s_tdata[61:52]),
		.offset_hours   (s_tdata[66:62]),
		.offset_minutes (s_tdata[72:67]),
		.result_year    (result_year),
		.result_month   (result_month),
		.result_day     (result_day),
		.result_hour    (result_hour),
		.result_minute  (result_minute),
		.status         (status)
	);

	// Pack the result beat.
	assign m_tdata = {6'd0, result_minute, result_hour, result_day, result_month, result_year};
	assign m_tuser = status;

endmodule
